@@ src/two_link_inverse_kinematics_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Two-link inverse kinematics unit: assertion macros
// Concurrent assertion helpers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_LINK_INVERSE_KINEMATICS_UNIT_DEFINES_SVH
`define TWO_LINK_INVERSE_KINEMATICS_UNIT_DEFINES_SVH

`ifndef SYNTH
`define TLIK_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tlik assertion failed");
`define TLIK_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tlik assertion failed");
`else
`define TLIK_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TLIK_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ src/tlik_pkg.sv @@
// ----------------------------------------------------------------------------
// Two-link inverse kinematics package
// Widths, payload types, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package tlik_pkg;

    localparam int COORD_WIDTH       = 16;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int LINK_W            = 15;
    localparam int CFG_INDEX_W       = 2;
    localparam int ANGLE_OUT_W       = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_UPPER_LINK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOWER_LINK = 2'd1;
    localparam logic [LINK_W-1:0]      LINK_RESET     = 15'd1600;

    localparam int WIDE_W        = (2 * COORD_WIDTH > 32) ? 2 * COORD_WIDTH : 32;
    localparam int SQ_IN_W       = 50;
    localparam int SQ_OUT_W      = 25;
    localparam int SQRT_STAGES   = SQ_OUT_W;
    localparam int CORDIC_W      = ((COORD_WIDTH + 7 > 32) ? COORD_WIDTH + 7 : 32) + 3;
    localparam int CORDIC_STAGES = CORDIC_ITERATIONS + 1;
    localparam int ANG_W         = 28;
    localparam int FRAC_W        = 16;
    localparam int MAX_DEG       = 180;

    typedef logic signed [CORDIC_W-1:0] cordic_t;
    typedef logic signed [ANG_W-1:0]    angle_t;

    localparam angle_t DEG_90  = angle_t'(90 * 65536);
    localparam angle_t DEG_180 = angle_t'(180 * 65536);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] reach;
        logic signed [COORD_WIDTH-1:0] height;
    } in_t;

    typedef struct packed {
        logic [ANGLE_OUT_W-1:0] shoulder_angle;
        logic [ANGLE_OUT_W-1:0] elbow_angle;
        logic                   reachable;
    } out_t;

    function automatic angle_t atan_q16(input int unsigned i);
        angle_t a;
        unique case (i)
            0:  a = angle_t'(2949120);
            1:  a = angle_t'(1740967);
            2:  a = angle_t'(919879);
            3:  a = angle_t'(466945);
            4:  a = angle_t'(234379);
            5:  a = angle_t'(117304);
            6:  a = angle_t'(58666);
            7:  a = angle_t'(29335);
            8:  a = angle_t'(14668);
            9:  a = angle_t'(7334);
            10: a = angle_t'(3667);
            11: a = angle_t'(1833);
            12: a = angle_t'(917);
            13: a = angle_t'(458);
            14: a = angle_t'(229);
            15: a = angle_t'(115);
            16: a = angle_t'(57);
            17: a = angle_t'(29);
            18: a = angle_t'(14);
            19: a = angle_t'(7);
            20: a = angle_t'(4);
            21: a = angle_t'(2);
            22: a = angle_t'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ src/tlik_sqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module tlik_sqrt (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [tlik_pkg::SQ_IN_W-1:0]  radicand,
    output logic [tlik_pkg::SQ_OUT_W-1:0] root
);

    localparam int IW = tlik_pkg::SQ_IN_W;
    localparam int OW = tlik_pkg::SQ_OUT_W;
    localparam int XW = IW + 2;

    logic [IW-1:0] rem_reg  [0:OW-1];
    logic [OW-1:0] root_reg [0:OW-1];

    for (genvar j = 0; j < OW; j++) begin : g_step
        localparam int B = OW - 1 - j;
        logic [IW-1:0] rem_i;
        logic [OW-1:0] root_i;
        logic [XW-1:0] trial;
        logic          fits;

        if (j == 0) begin : g_first
            assign rem_i  = radicand;
            assign root_i = '0;
        end else begin : g_next
            assign rem_i  = rem_reg[j-1];
            assign root_i = root_reg[j-1];
        end

        assign trial = (XW'(root_i) << (B + 1)) + (XW'(1) << (2 * B));
        assign fits  = XW'(rem_i) >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= fits ? IW'(XW'(rem_i) - trial) : rem_i;
                root_reg[j] <= fits ? (root_i | (OW'(1) << B)) : root_i;
            end
        end
    end

    assign root = root_reg[OW-1];

endmodule

@@ src/tlik_cordic.sv @@
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// atan2(y, x) in degrees with 16 fraction bits, one micro-rotation per stage.
// ----------------------------------------------------------------------------
module tlik_cordic (
    input  logic              aclk,
    input  logic              en,
    input  tlik_pkg::cordic_t x_in,
    input  tlik_pkg::cordic_t y_in,
    output tlik_pkg::angle_t  angle
);

    localparam int N = tlik_pkg::CORDIC_ITERATIONS;

    tlik_pkg::cordic_t x_reg   [0:N];
    tlik_pkg::cordic_t y_reg   [0:N];
    tlik_pkg::angle_t  ang_reg [0:N];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (x_in < 0) begin
                if (y_in >= 0) begin
                    x_reg[0]   <= y_in;
                    y_reg[0]   <= -x_in;
                    ang_reg[0] <= tlik_pkg::DEG_90;
                end else begin
                    x_reg[0]   <= -y_in;
                    y_reg[0]   <= x_in;
                    ang_reg[0] <= -tlik_pkg::DEG_90;
                end
            end else begin
                x_reg[0]   <= x_in;
                y_reg[0]   <= y_in;
                ang_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        tlik_pkg::cordic_t dx;
        tlik_pkg::cordic_t dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                unique if (y_reg[i] == 0) begin
                    x_reg[i+1]   <= x_reg[i];
                    y_reg[i+1]   <= y_reg[i];
                    ang_reg[i+1] <= ang_reg[i];
                end else if (y_reg[i] > 0) begin
                    x_reg[i+1]   <= x_reg[i] + dx;
                    y_reg[i+1]   <= y_reg[i] - dy;
                    ang_reg[i+1] <= ang_reg[i] + tlik_pkg::atan_q16(i);
                end else if (y_reg[i] < 0) begin
                    x_reg[i+1]   <= x_reg[i] - dx;
                    y_reg[i+1]   <= y_reg[i] + dy;
                    ang_reg[i+1] <= ang_reg[i] - tlik_pkg::atan_q16(i);
                end
            end
        end
    end

    assign angle = ang_reg[N];

endmodule

@@ src/two_link_inverse_kinematics_unit.sv @@
// ----------------------------------------------------------------------------
// Two-link inverse kinematics unit
// Shoulder and elbow angles of a planar two-link arm for one target.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one target (reach, height) per transaction, the
//   m_ channel one result (shoulder_angle, elbow_angle, reachable).
//   Link lengths are set through cfg_wr_en / cfg_index / cfg_data, index 0
//   upper link, index 1 lower link; write them only while no transaction
//   is in flight.
//   From input transaction to result valid there are 2 squaring and range
//   stages, 25 square-root stages, 3 law-of-cosines stages, 25 more
//   square-root stages, 17 CORDIC stages and the output register.
//   Throughput is one transaction per cycle when not stalled; every stage is a register.
//   A stalled receiver freezes the whole pipeline; s_ready drops while the
//   output register holds a result that is not taken. Nothing is lost.
//   Reset empties the pipeline and loads both link lengths with 1600.
//   An out-of-reach or zero-distance target gives reachable 0, angles 0.
// ----------------------------------------------------------------------------
`include "two_link_inverse_kinematics_unit_defines.svh"

module two_link_inverse_kinematics_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tlik_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tlik_pkg::LINK_W-1:0]        cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  tlik_pkg::in_t                      s_payload,
    output logic                               m_valid,
    input  logic                               m_ready,
    output tlik_pkg::out_t                     m_payload
);

    localparam int CW  = tlik_pkg::COORD_WIDTH;
    localparam int WSQ = 2 * CW;
    localparam int WW  = tlik_pkg::WIDE_W;
    localparam int IW  = tlik_pkg::SQ_IN_W;
    localparam int OW  = tlik_pkg::SQ_OUT_W;
    localparam int TW  = OW + 2;
    localparam int SW  = OW + 1;
    localparam int LW  = tlik_pkg::LINK_W;
    localparam int NSQ = tlik_pkg::SQRT_STAGES;
    localparam int NCR = tlik_pkg::CORDIC_STAGES;

    typedef struct packed {
        logic                 valid;
        logic                 reach;
        logic signed [CW-1:0] r;
        logic signed [CW-1:0] z;
        logic [OW-1:0]        er;
        logic [OW-1:0]        em;
    } side_t;

    logic [LW-1:0]  upper_reg;
    logic [LW-1:0]  lower_reg;
    logic [31:0]    sumsq_reg;
    logic [31:0]    diffsq_reg;
    logic [2*LW-1:0] l2sq_reg;
    logic [LW:0]    sum_c;
    logic [LW-1:0]  diff_c;

    logic adv;

    side_t          st1_reg;
    logic [WSQ-1:0] rsq_reg;
    logic [WSQ-1:0] zsq_reg;
    logic signed [WSQ-1:0] rsq_c;
    logic signed [WSQ-1:0] zsq_c;

    side_t          st2_reg;
    logic [31:0]    dsq_reg;
    logic [31:0]    ebma_reg;
    logic [31:0]    ebpa_reg;
    logic [WW-1:0]  dsq_c;
    logic           reach_c;

    side_t          sa_reg [0:NSQ-1];
    logic [OW-1:0]  dq_root;
    logic [OW-1:0]  ebpa_root;
    logic [OW-1:0]  ebma_root;

    side_t                 st3_reg;
    logic signed [TW-1:0]  t_reg;
    logic [SW-1:0]         s_reg;
    logic signed [TW-1:0]  t_c;
    logic [SW-1:0]         s_c;
    logic [LW+7:0]         l1q_c;

    side_t                   st4_reg;
    logic [IW-1:0]           tsq_reg;
    logic [IW-1:0]           ssq_reg;
    logic signed [2*TW-1:0]  tsq_c;
    logic [2*SW-1:0]         ssq_c;

    side_t          st5_reg;
    logic [IW-1:0]  bma_reg;
    logic [IW-1:0]  bpa_reg;
    logic [IW-1:0]  l2q_c;

    side_t          sb_reg [0:NSQ-1];
    logic [OW-1:0]  bpa_root;
    logic [OW-1:0]  bma_root;

    side_t             cr_reg [0:NCR-1];
    tlik_pkg::angle_t  base_ang;
    tlik_pkg::angle_t  half1_ang;
    tlik_pkg::angle_t  half2_ang;

    tlik_pkg::angle_t  sh_c;
    tlik_pkg::angle_t  el_c;
    logic              m_valid_reg;
    tlik_pkg::out_t    m_payload_reg;

    function automatic logic [tlik_pkg::ANGLE_OUT_W-1:0] to_deg(input tlik_pkg::angle_t q);
        logic signed [tlik_pkg::ANG_W-1:0] w;
        logic [tlik_pkg::ANGLE_OUT_W-1:0]  d;
        w = q >>> tlik_pkg::FRAC_W;
        if (q < 0) begin
            d = '0;
        end else if (w > tlik_pkg::MAX_DEG) begin
            d = tlik_pkg::ANGLE_OUT_W'(tlik_pkg::MAX_DEG);
        end else begin
            d = w[tlik_pkg::ANGLE_OUT_W-1:0];
        end
        return d;
    endfunction

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg <= tlik_pkg::LINK_RESET;
            lower_reg <= tlik_pkg::LINK_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tlik_pkg::CFG_UPPER_LINK: upper_reg <= cfg_data;
                tlik_pkg::CFG_LOWER_LINK: lower_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign sum_c  = (LW+1)'(upper_reg) + (LW+1)'(lower_reg);
    assign diff_c = (upper_reg > lower_reg) ? upper_reg - lower_reg : lower_reg - upper_reg;

    always_ff @(posedge aclk) begin
        sumsq_reg  <= 32'(sum_c) * 32'(sum_c);
        diffsq_reg <= 32'(diff_c) * 32'(diff_c);
        l2sq_reg   <= (2*LW)'(lower_reg) * (2*LW)'(lower_reg);
    end

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // squares
    assign rsq_c = WSQ'(s_payload.reach) * WSQ'(s_payload.reach);
    assign zsq_c = WSQ'(s_payload.height) * WSQ'(s_payload.height);

    // range check and elbow terms
    assign dsq_c   = WW'(rsq_reg) + WW'(zsq_reg);
    assign reach_c = (dsq_c != '0) && (dsq_c <= WW'(sumsq_reg)) && (dsq_c >= WW'(diffsq_reg));

    tlik_sqrt u_sqrt_dq (
        .aclk     (aclk),
        .en       (adv),
        .radicand (IW'({dsq_reg, 16'b0})),
        .root     (dq_root)
    );

    tlik_sqrt u_sqrt_ebpa (
        .aclk     (aclk),
        .en       (adv),
        .radicand (IW'(ebpa_reg)),
        .root     (ebpa_root)
    );

    tlik_sqrt u_sqrt_ebma (
        .aclk     (aclk),
        .en       (adv),
        .radicand (IW'(ebma_reg)),
        .root     (ebma_root)
    );

    // shoulder law of cosines
    assign l1q_c = {upper_reg, 8'b0};
    assign t_c   = signed'(TW'(dq_root)) - signed'(TW'(l1q_c));
    assign s_c   = SW'(dq_root) + SW'(l1q_c);
    assign tsq_c = (2*TW)'(t_reg) * (2*TW)'(t_reg);
    assign ssq_c = (2*SW)'(s_reg) * (2*SW)'(s_reg);
    assign l2q_c = IW'({l2sq_reg, 16'b0});

    tlik_sqrt u_sqrt_bpa (
        .aclk     (aclk),
        .en       (adv),
        .radicand (bpa_reg),
        .root     (bpa_root)
    );

    tlik_sqrt u_sqrt_bma (
        .aclk     (aclk),
        .en       (adv),
        .radicand (bma_reg),
        .root     (bma_root)
    );

    tlik_cordic u_cordic_base (
        .aclk  (aclk),
        .en    (adv),
        .x_in  (tlik_pkg::cordic_t'(sb_reg[NSQ-1].r) <<< 6),
        .y_in  (tlik_pkg::cordic_t'(sb_reg[NSQ-1].z) <<< 6),
        .angle (base_ang)
    );

    tlik_cordic u_cordic_half1 (
        .aclk  (aclk),
        .en    (adv),
        .x_in  (tlik_pkg::cordic_t'(bpa_root) <<< 6),
        .y_in  (tlik_pkg::cordic_t'(bma_root) <<< 6),
        .angle (half1_ang)
    );

    tlik_cordic u_cordic_half2 (
        .aclk  (aclk),
        .en    (adv),
        .x_in  (tlik_pkg::cordic_t'(sb_reg[NSQ-1].er) <<< 6),
        .y_in  (tlik_pkg::cordic_t'(sb_reg[NSQ-1].em) <<< 6),
        .angle (half2_ang)
    );

    assign sh_c = base_ang + ((upper_reg == '0) ? tlik_pkg::angle_t'(0) : (half1_ang <<< 1));
    assign el_c = tlik_pkg::DEG_180 - (half2_ang <<< 1);

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_reg.valid <= 1'b0;
            st2_reg.valid <= 1'b0;
            st3_reg.valid <= 1'b0;
            st4_reg.valid <= 1'b0;
            st5_reg.valid <= 1'b0;
            for (int k = 0; k < NSQ; k++) begin
                sa_reg[k].valid <= 1'b0;
                sb_reg[k].valid <= 1'b0;
            end
            for (int k = 0; k < NCR; k++) begin
                cr_reg[k].valid <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            st1_reg.valid <= s_valid;
            st1_reg.reach <= 1'b0;
            st1_reg.r     <= s_payload.reach;
            st1_reg.z     <= s_payload.height;
            st1_reg.er    <= '0;
            st1_reg.em    <= '0;
            rsq_reg       <= rsq_c;
            zsq_reg       <= zsq_c;

            st2_reg       <= '{valid: st1_reg.valid, reach: reach_c, r: st1_reg.r,
                               z: st1_reg.z, er: st1_reg.er, em: st1_reg.em};
            dsq_reg       <= dsq_c[31:0];
            ebma_reg      <= dsq_c[31:0] - diffsq_reg;
            ebpa_reg      <= sumsq_reg - dsq_c[31:0];

            sa_reg[0] <= st2_reg;
            for (int k = 1; k < NSQ; k++) begin
                sa_reg[k] <= sa_reg[k-1];
            end

            st3_reg    <= '{valid: sa_reg[NSQ-1].valid, reach: sa_reg[NSQ-1].reach,
                            r: sa_reg[NSQ-1].r, z: sa_reg[NSQ-1].z,
                            er: ebpa_root, em: ebma_root};
            t_reg      <= t_c;
            s_reg      <= s_c;

            st4_reg <= st3_reg;
            tsq_reg <= tsq_c[IW-1:0];
            ssq_reg <= ssq_c[IW-1:0];

            st5_reg <= st4_reg;
            bma_reg <= (l2q_c >= tsq_reg) ? l2q_c - tsq_reg : '0;
            bpa_reg <= (ssq_reg >= l2q_c) ? ssq_reg - l2q_c : '0;

            sb_reg[0] <= st5_reg;
            for (int k = 1; k < NSQ; k++) begin
                sb_reg[k] <= sb_reg[k-1];
            end

            cr_reg[0] <= sb_reg[NSQ-1];
            for (int k = 1; k < NCR; k++) begin
                cr_reg[k] <= cr_reg[k-1];
            end

            m_valid_reg <= cr_reg[NCR-1].valid;
            if (cr_reg[NCR-1].reach) begin
                m_payload_reg.shoulder_angle <= to_deg(sh_c);
                m_payload_reg.elbow_angle    <= to_deg(el_c);
                m_payload_reg.reachable      <= 1'b1;
            end else begin
                m_payload_reg <= '0;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    `TLIK_ASSERT_IMP(a_unreach_zero, aclk, aresetn, m_valid && !m_payload.reachable, m_payload.shoulder_angle == '0 && m_payload.elbow_angle == '0)
    `TLIK_ASSERT_IMP(a_angle_range, aclk, aresetn, m_valid, m_payload.shoulder_angle <= 8'd180 && m_payload.elbow_angle <= 8'd180)
    `TLIK_ASSERT_NXT(a_last_to_out, aclk, aresetn, cr_reg[NCR-1].valid && s_ready, m_valid)

endmodule

@@ tb/sv/tb_two_link_inverse_kinematics_unit.sv @@
// ----------------------------------------------------------------------------
// Two-link inverse kinematics unit testbench
// Drives random and directed targets through the unit, predicts each result
// with a bit-exact model of the CORDIC and square-root arithmetic, and checks
// every output transaction in order. Link lengths are changed between phases.
// ----------------------------------------------------------------------------
module tb_two_link_inverse_kinematics_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 73;
    localparam int WDOG_MAX  = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [tlik_pkg::CFG_INDEX_W-1:0] cfg_index = tlik_pkg::CFG_UPPER_LINK;
    logic [tlik_pkg::LINK_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    tlik_pkg::in_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    tlik_pkg::out_t m_payload;

    int errors = 0;
    int idle_cycles = 0;
    bit hold_rx = 1'b0;
    bit no_idle = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    two_link_inverse_kinematics_unit u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    class ik_scoreboard;
        longint upper_len = 1600;
        longint lower_len = 1600;
        tlik_pkg::out_t pending_angles[$];

        function automatic longint isqrt(input longint unsigned v);
            longint unsigned root, bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v -= root + bitv;
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            return longint'(root);
        endfunction

        function automatic longint fshift(input longint v, input int s);
            return v >>> s;
        endfunction

        function automatic longint atan2_deg(input longint x, input longint y);
            longint ang, t, dx, dy;
            ang = 0;
            if (x == 0 && y == 0) return 0;
            x *= 64;
            y *= 64;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; ang = 90 * 65536;
                end else begin
                    x = -y; y = t; ang = -90 * 65536;
                end
            end
            for (int i = 0; i < tlik_pkg::CORDIC_ITERATIONS && i < 24; i++) begin
                if (y == 0) break;
                dx = fshift(y, i);
                dy = fshift(x, i);
                if (y > 0) begin
                    x += dx; y -= dy; ang += longint'(tlik_pkg::atan_q16(i));
                end else begin
                    x -= dx; y += dy; ang -= longint'(tlik_pkg::atan_q16(i));
                end
            end
            return ang;
        endfunction

        function automatic logic [7:0] to_deg(input longint q);
            longint w;
            if (q < 0) return 8'd0;
            w = q >>> 16;
            return (w > 180) ? 8'd180 : 8'(w);
        endfunction

        function automatic void note_target(input tlik_pkg::in_t t);
            longint r, z, dsq, sm, df, base, half1, half2, dq, l1q, l2sq, a, b;
            tlik_pkg::out_t o;
            r = longint'(t.reach);
            z = longint'(t.height);
            dsq = r * r + z * z;
            sm = upper_len + lower_len;
            df = (upper_len > lower_len) ? upper_len - lower_len : lower_len - upper_len;
            o = '0;
            if (!(dsq == 0 || dsq > sm * sm || dsq < df * df)) begin
                base = atan2_deg(r, z);
                half1 = 0;
                if (upper_len != 0) begin
                    dq = isqrt(longint'(dsq) << 16);
                    l1q = upper_len * 256;
                    l2sq = lower_len * lower_len * 65536;
                    a = l2sq - (dq - l1q) * (dq - l1q);
                    b = (dq + l1q) * (dq + l1q) - l2sq;
                    if (a < 0) a = 0;
                    if (b < 0) b = 0;
                    half1 = atan2_deg(isqrt(b), isqrt(a));
                end
                a = dsq - df * df;
                b = sm * sm - dsq;
                if (a < 0) a = 0;
                if (b < 0) b = 0;
                half2 = atan2_deg(isqrt(b), isqrt(a));
                o.shoulder_angle = to_deg(base + 2 * half1);
                o.elbow_angle = to_deg(180 * 65536 - 2 * half2);
                o.reachable = 1'b1;
            end
            pending_angles.push_back(o);
        endfunction

        task automatic check_result(input tlik_pkg::out_t got);
            tlik_pkg::out_t exp;
            if (pending_angles.size() == 0) begin
                report_mismatch("result with no pending target");
                return;
            end
            exp = pending_angles.pop_front();
            if (got.shoulder_angle !== exp.shoulder_angle)
                report_mismatch($sformatf("shoulder got %0d exp %0d",
                    got.shoulder_angle, exp.shoulder_angle));
            if (got.elbow_angle !== exp.elbow_angle)
                report_mismatch($sformatf("elbow got %0d exp %0d",
                    got.elbow_angle, exp.elbow_angle));
            if (got.reachable !== exp.reachable)
                report_mismatch($sformatf("reachable got %0d exp %0d",
                    got.reachable, exp.reachable));
        endtask
    endclass

    ik_scoreboard sb = new();

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_target(s_payload);
            if (m_valid && m_ready) sb.check_result(m_payload);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG_MAX) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // receiver: random backpressure, or a long hold-off
    initial begin
        int hold;
        forever begin
            @(posedge aclk);
            if (hold_rx) begin
                m_ready <= 1'b0;
                for (hold = 0; hold < 300; hold++) @(posedge aclk);
                hold_rx = 1'b0;
            end
            m_ready <= no_idle || ($urandom_range(99) >= 38);
        end
    end

    task automatic write_link(input logic [tlik_pkg::CFG_INDEX_W-1:0] idx,
                              input logic [tlik_pkg::LINK_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == tlik_pkg::CFG_UPPER_LINK) sb.upper_len = v;
        else if (idx == tlik_pkg::CFG_LOWER_LINK) sb.lower_len = v;
    endtask

    task automatic send_target(input logic [15:0] r, input logic [15:0] z);
        while (!no_idle && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= {r, z};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (sb.pending_angles.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic logic [15:0] scaled_coord(input int span);
        int v;
        v = int'($urandom_range(2 * span)) - span;
        return 16'(v);
    endfunction

    task automatic random_phase(input int n);
        int span;
        span = int'(sb.upper_len + sb.lower_len + 64);
        if (span > 32767) span = 32767;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 2)
                send_target(16'($urandom), 16'($urandom));
            else
                send_target(scaled_coord(span), scaled_coord(span));
        end
    endtask

    initial begin
        logic [15:0] dr [12];
        logic [15:0] dz [12];
        dr = '{16'h7FFF, 16'h8000, 16'd0, 16'd0, 16'd3200, 16'hF380, 16'd0,
               16'd0, 16'd1600, 16'hF9C0, 16'd1, 16'hFFFF};
        dz = '{16'h7FFF, 16'h8000, 16'd0, 16'd3200, 16'd0, 16'd0, 16'hF380,
               16'd1600, 16'd1600, 16'hF9C0, 16'd0, 16'hFFFF};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < 12; i++) send_target(dr[i], dz[i]);
        drain();
        write_link(tlik_pkg::CFG_UPPER_LINK, 15'd0);
        write_link(tlik_pkg::CFG_LOWER_LINK, 15'd1000);
        for (int i = 0; i < 6; i++) send_target(16'd1000, 16'($urandom_range(200)));
        send_target(16'd0, 16'd1000);
        drain();
        write_link(tlik_pkg::CFG_UPPER_LINK, 15'd1000);
        write_link(tlik_pkg::CFG_LOWER_LINK, 15'd0);
        send_target(16'd1000, 16'd0);
        send_target(16'd0, 16'hFC18);
        send_target(16'hFC18, 16'd0);
        drain();
        write_link(tlik_pkg::CFG_UPPER_LINK, 15'd1600);
        write_link(tlik_pkg::CFG_LOWER_LINK, 15'd1600);
        no_idle = 1'b1;
        random_phase(200);
        no_idle = 1'b0;
        hold_rx = 1'b1;
        random_phase(300);
        drain();
        write_link(tlik_pkg::CFG_UPPER_LINK, 15'h7FFF);
        write_link(tlik_pkg::CFG_LOWER_LINK, 15'h7FFF);
        random_phase(250);
        drain();
        write_link(tlik_pkg::CFG_UPPER_LINK, 15'd37);
        write_link(tlik_pkg::CFG_LOWER_LINK, 15'd5000);
        random_phase(250);
        drain();
        write_link(tlik_pkg::CFG_UPPER_LINK, 15'($urandom));
        write_link(tlik_pkg::CFG_LOWER_LINK, 15'($urandom));
        random_phase(250);
        drain();
        write_link(tlik_pkg::CFG_UPPER_LINK, 15'd2000);
        write_link(tlik_pkg::CFG_LOWER_LINK, 15'd1200);
        random_phase(250);
        drain();
        if (errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
